[hw/rtl/numeric_range_filter_assert.svh]
// assertion macros for the numeric range filter
`ifndef NUMERIC_RANGE_FILTER_ASSERT_SVH
`define NUMERIC_RANGE_FILTER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define NRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication checked in the cycle after the condition holds
`define NRF_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

[hw/rtl/nrf_pkg.sv]
// package: constants, types and compare functions for the numeric range filter
`default_nettype none
package nrf_pkg;
  localparam int DocIdWidthDefault = 31;
  localparam int CountWidth = 31;
  localparam int ValueWidth = 64;
  localparam int CfgIndexWidth = 3;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_LOWER_BOUND     = 3'd0,
    REG_UPPER_BOUND     = 3'd1,
    REG_LOWER_INCLUSIVE = 3'd2,
    REG_UPPER_INCLUSIVE = 3'd3,
    REG_DOUBLE_MODE     = 3'd4,
    REG_DOC_COUNT       = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    REQ_PAIR = 1'b0,
    REQ_SKIP = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [ValueWidth-1:0] lower_bound;
    logic [ValueWidth-1:0] upper_bound;
    logic                  lower_inclusive;
    logic                  upper_inclusive;
    logic                  double_mode;
    logic [CountWidth-1:0] doc_count;
  } nrf_cfg_t;

  // double is nan
  function automatic logic is_nan(input logic [ValueWidth-1:0] v);
    return (v[62:52] == 11'h7ff) && (v[51:0] != '0);
  endfunction

  // order key: integer-style ordering of doubles, zeros folded together
  function automatic logic [ValueWidth-1:0] dbl_key(input logic [ValueWidth-1:0] v);
    logic [ValueWidth-1:0] k;
    if (v[62:0] == '0) begin
      k = {1'b1, 63'd0};
    end else if (v[63]) begin
      k = ~v;
    end else begin
      k = {1'b1, v[62:0]};
    end
    return k;
  endfunction
endpackage
`default_nettype wire

[hw/rtl/nrf_stream_if.sv]
// valid/ready stream interface
`default_nettype none
interface nrf_stream_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/nrf_cfg_regs.sv]
// configuration register bank
`default_nettype none
module nrf_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [nrf_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [nrf_pkg::ValueWidth-1:0]  cfg_data,
  output nrf_pkg::nrf_cfg_t                   cfg
);
  import nrf_pkg::*;
  nrf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower_bound     <= {1'b1, 63'd0};
      cfg_r.upper_bound     <= {1'b0, {63{1'b1}}};
      cfg_r.lower_inclusive <= 1'b1;
      cfg_r.upper_inclusive <= 1'b1;
      cfg_r.double_mode     <= 1'b0;
      cfg_r.doc_count       <= {CountWidth{1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOWER_BOUND:     cfg_r.lower_bound     <= cfg_data;
        REG_UPPER_BOUND:     cfg_r.upper_bound     <= cfg_data;
        REG_LOWER_INCLUSIVE: cfg_r.lower_inclusive <= cfg_data[0];
        REG_UPPER_INCLUSIVE: cfg_r.upper_inclusive <= cfg_data[0];
        REG_DOUBLE_MODE:     cfg_r.double_mode     <= cfg_data[0];
        REG_DOC_COUNT:       cfg_r.doc_count       <= cfg_data[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

[hw/rtl/nrf_range_cmp.sv]
// range predicate on one 64-bit value
`default_nettype none
module nrf_range_cmp (
  input  nrf_pkg::nrf_cfg_t                 cfg,
  input  wire logic [nrf_pkg::ValueWidth-1:0] value,
  output logic                              in_range
);
  import nrf_pkg::*;
  logic [ValueWidth-1:0] v_k, lo_k, hi_k;
  logic lo_ok, hi_ok, lo_nan, hi_nan;

  always_comb begin
    lo_nan = 1'b0;
    hi_nan = 1'b0;
    if (cfg.double_mode) begin
      v_k    = dbl_key(value);
      lo_k   = dbl_key(cfg.lower_bound);
      hi_k   = dbl_key(cfg.upper_bound);
      lo_nan = is_nan(cfg.lower_bound);
      hi_nan = is_nan(cfg.upper_bound);
    end else begin
      v_k  = value ^ {1'b1, 63'd0};
      lo_k = cfg.lower_bound ^ {1'b1, 63'd0};
      hi_k = cfg.upper_bound ^ {1'b1, 63'd0};
    end
    lo_ok = lo_nan || (cfg.lower_inclusive ? (v_k >= lo_k) : (v_k > lo_k));
    hi_ok = hi_nan || (cfg.upper_inclusive ? (v_k <= hi_k) : (v_k < hi_k));
    in_range = lo_ok && hi_ok && !(cfg.double_mode && is_nan(value));
  end
endmodule
`default_nettype wire

[hw/rtl/numeric_range_filter.sv]
// numeric range filter top level
// Takes one transaction per cycle unless out_s stalls and returns one result per
// transaction in the following cycle through a registered output stage; throughput
// is set by the combinational 64-bit range compare and the skip-floor update.
// Configuration may be written only while no transaction is in flight.
`default_nettype none
module numeric_range_filter #(
  parameter int DOC_ID_WIDTH = nrf_pkg::DocIdWidthDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nrf_stream_if.sink   in_s,
  nrf_stream_if.source out_s,
  input  wire logic                              cfg_we,
  input  wire logic [nrf_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [nrf_pkg::ValueWidth-1:0]    cfg_data
);
  import nrf_pkg::*;
  `include "numeric_range_filter_assert.svh"

  // input payload: {req_type, doc_id, raw_value}
  // output payload: {hit, doc_id, exhausted}
  nrf_cfg_t cfg;
  logic                    req_type;
  logic [DOC_ID_WIDTH-1:0] doc_id;
  logic [ValueWidth-1:0]   raw_value;
  logic                    in_rng, accept, take;
  logic [CountWidth+1:0]   id_ext, cnt_ext;
  logic [DOC_ID_WIDTH-1:0] floor_r, floor_nxt;
  logic                    done_r, done_nxt, hit_nxt;
  logic                    ov_r, hit_r, exh_r;
  logic [CountWidth-1:0]   doc_r, doc_nxt;

  nrf_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  assign req_type  = in_s.payload[CountWidth+ValueWidth];
  assign doc_id    = DOC_ID_WIDTH'(in_s.payload[CountWidth+ValueWidth-1:ValueWidth]);
  assign raw_value = in_s.payload[ValueWidth-1:0];

  nrf_range_cmp u_cmp (.cfg, .value(raw_value), .in_range(in_rng));

  assign in_s.ready = !ov_r || out_s.ready;
  assign accept     = in_s.valid && in_s.ready;
  assign take       = out_s.valid && out_s.ready;

  always_comb begin
    id_ext    = (CountWidth+2)'(doc_id);
    cnt_ext   = (CountWidth+2)'(cfg.doc_count);
    floor_nxt = floor_r;
    done_nxt  = done_r;
    hit_nxt   = 1'b0;
    if (req_type == REQ_SKIP) begin
      if (id_ext >= cnt_ext) begin
        done_nxt = 1'b1;
      end else if (doc_id > floor_r) begin
        floor_nxt = doc_id;
      end
    end else begin
      hit_nxt = !done_r && (doc_id >= floor_r) && (id_ext < cnt_ext) && in_rng;
    end
    doc_nxt = CountWidth'(doc_id);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (accept) begin
        floor_r <= floor_nxt;
        done_r  <= done_nxt;
        ov_r    <= 1'b1;
      end else if (take) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r <= hit_nxt;
      doc_r <= doc_nxt;
      exh_r <= done_nxt;
    end
  end

  assign out_s.valid   = ov_r;
  assign out_s.payload = {hit_r, doc_r, exh_r};

  `NRF_ASSERT(a_hit_not_exh, !(out_s.valid && hit_r && exh_r))
  `NRF_ASSERT_NEXT(a_done_sticky, done_r, done_r)
  `NRF_ASSERT_NEXT(a_floor_mono, !accept, $stable(floor_r))
endmodule
`default_nettype wire
